// ----- hw/rtl/aib_pkg.sv -----
// ----------------------------------------------------------------------------
// aib_pkg
// Shared types, codes and constants of the attention importance bank.
// ----------------------------------------------------------------------------
`default_nettype none

package aib_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int OP_W      = 2;
  localparam int INDEX_W   = 4;
  localparam int ACT_W     = 16;
  localparam int IMP_W     = 15;
  localparam int STAMP_W   = 32;
  localparam int TOTAL_W   = 20;
  localparam int WAGE_W    = 10;
  localparam int RENT_W    = 10;
  localparam int LIVE_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 15;

  // activity (signed 16) times wage (unsigned 10): 27-bit signed product
  localparam int PROD_W = ACT_W + WAGE_W + 1;
  localparam int FRAC_W = 8;
  localparam int INC_W  = PROD_W - FRAC_W;
  localparam int SUM_W  = INC_W + 1;

  localparam logic [WAGE_W-1:0]        WAGE_RST    = 10'd10;
  localparam logic [RENT_W-1:0]        RENT_RST    = 10'd1;
  localparam logic signed [IMP_W-1:0]  IMP_MAX_RST = 15'sd1000;
  localparam logic signed [IMP_W-1:0]  IMP_MIN_RST = -15'sd1000;
  localparam logic [LIVE_W-1:0]        LIVE_RST    = 5'd0;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_DECAY  = 2'd1,
    OP_FOCUS  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAGE    = 3'd0,
    REG_RENT    = 3'd1,
    REG_IMP_MAX = 3'd2,
    REG_IMP_MIN = 3'd3,
    REG_LIVE    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IMP_W-1:0]   imp;
    logic [STAMP_W-1:0] stamp;
  } cell_data_t;

  typedef struct packed {
    op_t  op;
    logic live;
    logic hit;
  } head_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/aib_cell.sv -----
// ----------------------------------------------------------------------------
// aib_cell
// One entry of the ring: holds importance and stamp, takes its neighbor's
// contents on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module aib_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift,
  input  wire aib_pkg::cell_data_t d_in,
  output aib_pkg::cell_data_t      d_out
);

  aib_pkg::cell_data_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= d_in;
    end
  end

  assign d_out = data;

endmodule

`default_nettype wire

// ----- hw/rtl/aib_head.sv -----
// ----------------------------------------------------------------------------
// aib_head
// Update unit on the ring's wrap link: access pay-in with clamp, decay with
// floor, focus threshold test for the entry at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module aib_head (
  input  wire aib_pkg::head_ctrl_t                    ctrl,
  input  wire aib_pkg::cell_data_t                    cur,
  input  wire logic signed [aib_pkg::INC_W-1:0]       inc,
  input  wire logic [aib_pkg::STAMP_W-1:0]            tick,
  input  wire logic [aib_pkg::RENT_W-1:0]             rent,
  input  wire logic signed [aib_pkg::IMP_W-1:0]       imp_max,
  input  wire logic signed [aib_pkg::IMP_W-1:0]       imp_min,
  input  wire logic signed [aib_pkg::IMP_W-1:0]       thr,
  output aib_pkg::cell_data_t                         nxt,
  output logic                                        listed
);

  localparam int SUM_W = aib_pkg::SUM_W;
  localparam int DEC_W = aib_pkg::IMP_W + 1;

  logic signed [aib_pkg::IMP_W-1:0] cur_imp;
  logic signed [SUM_W-1:0]          acc_sum;
  logic signed [DEC_W-1:0]          dec_diff;
  logic signed [DEC_W-1:0]          rent_s;

  assign cur_imp = cur.imp;
  assign rent_s  = DEC_W'(signed'({1'b0, rent}));

  always_comb begin
    acc_sum  = SUM_W'(cur_imp) + SUM_W'(inc);
    if (acc_sum > SUM_W'(imp_max)) acc_sum = SUM_W'(imp_max);
    if (acc_sum < SUM_W'(imp_min)) acc_sum = SUM_W'(imp_min);

    dec_diff = DEC_W'(cur_imp) - rent_s;
    if (dec_diff < DEC_W'(imp_min)) dec_diff = DEC_W'(imp_min);

    nxt    = cur;
    listed = 1'b0;
    case (ctrl.op)
      aib_pkg::OP_ACCESS: begin
        if (ctrl.hit) begin
          nxt.imp   = aib_pkg::IMP_W'(acc_sum);
          nxt.stamp = tick;
        end
      end
      aib_pkg::OP_DECAY: begin
        if (ctrl.live) nxt.imp = aib_pkg::IMP_W'(dec_diff);
      end
      aib_pkg::OP_FOCUS: begin
        listed = ctrl.live && (cur_imp > thr);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/attention_importance_bank.sv -----
// Access: multiply, scale, one ring pass, result. Decay and focus: one ring pass, result;
// a focus scan can stall on the output. The ring moves one entry per cycle, except while a
// focus hit waits on a full result slot; a new transaction is taken after the last result.
// Reset: table, tick counter and result valid flag cleared, registers to defaults;
// no clearing pass, ready as soon as reset falls.
// ----------------------------------------------------------------------------
// attention_importance_bank
// Short-term importance table kept in a rotating ring of cells; every
// operation rotates the ring once through a shared update unit.
// ----------------------------------------------------------------------------
`default_nettype none

module attention_importance_bank #(
  parameter int ENTRIES = aib_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic [aib_pkg::OP_W-1:0]            op,
  input  wire logic [aib_pkg::INDEX_W-1:0]         entry_index,
  input  wire logic signed [aib_pkg::ACT_W-1:0]    activity,
  input  wire logic signed [aib_pkg::IMP_W-1:0]    focus_threshold,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic                                     found,
  output logic [aib_pkg::INDEX_W-1:0]              result_index,
  output logic signed [aib_pkg::IMP_W-1:0]         importance,
  output logic [aib_pkg::STAMP_W-1:0]              stamp,
  output logic signed [aib_pkg::TOTAL_W-1:0]       total_importance,
  output logic                                     last,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [aib_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aib_pkg::CFG_W-1:0]           cfg_data
);

  localparam int K_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IMP_W = aib_pkg::IMP_W;
  localparam int STAMP_W = aib_pkg::STAMP_W;
  localparam int TOTAL_W = aib_pkg::TOTAL_W;
  localparam int PROD_W = aib_pkg::PROD_W;
  localparam int INC_W = aib_pkg::INC_W;
  localparam logic [K_W-1:0] K_LAST = K_W'(ENTRIES - 1);

  aib_pkg::state_t state, state_next;

  logic [aib_pkg::WAGE_W-1:0]   wage;
  logic [aib_pkg::RENT_W-1:0]   rent;
  logic signed [IMP_W-1:0]      imp_max;
  logic signed [IMP_W-1:0]      imp_min;
  logic [aib_pkg::LIVE_W-1:0]   entries_in_use;

  logic [K_W-1:0]               k;
  logic [STAMP_W-1:0]           tick;
  aib_pkg::op_t                 op_q;
  logic [aib_pkg::INDEX_W-1:0]  idx_q;
  logic signed [aib_pkg::ACT_W-1:0] act_q;
  logic signed [IMP_W-1:0]      thr_q;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     prod_rnd;
  logic signed [INC_W-1:0]      inc;

  logic                         hold_valid;
  logic [aib_pkg::INDEX_W-1:0]  hold_idx;
  logic signed [IMP_W-1:0]      hold_imp;
  logic [STAMP_W-1:0]           hold_stamp;
  logic signed [TOTAL_W-1:0]    total;

  aib_pkg::cell_data_t          cell_q  [ENTRIES];
  aib_pkg::cell_data_t          cell_in [ENTRIES];
  aib_pkg::cell_data_t          cur, nxt;
  aib_pkg::head_ctrl_t          ctrl;
  logic                         listed;
  logic signed [IMP_W-1:0]      cur_imp, nxt_imp;

  logic item_fire, slot_free, step, push_mid, push_final;

  // ring of cells, head at cell 0, update unit on the wrap link
  assign cur = cell_q[0];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_wrap
      assign cell_in[i] = nxt;
    end else begin : g_link
      assign cell_in[i] = cell_q[i+1];
    end
    aib_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d_in  (cell_in[i]),
      .d_out (cell_q[i])
    );
  end

  assign ctrl.op   = op_q;
  assign ctrl.live = 32'(k) < 32'(entries_in_use);
  assign ctrl.hit  = (op_q == aib_pkg::OP_ACCESS) && ctrl.live && (32'(k) == 32'(idx_q));

  aib_head u_head (
    .ctrl    (ctrl),
    .cur     (cur),
    .inc     (inc),
    .tick    (tick),
    .rent    (rent),
    .imp_max (imp_max),
    .imp_min (imp_min),
    .thr     (thr_q),
    .nxt     (nxt),
    .listed  (listed)
  );

  assign cur_imp = cur.imp;
  assign nxt_imp = nxt.imp;

  assign item_ready = !rst && (state == aib_pkg::S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign cfg_ready  = !rst && (state == aib_pkg::S_IDLE);
  assign slot_free  = !result_valid || result_ready;

  assign push_mid   = (state == aib_pkg::S_RUN) && (op_q == aib_pkg::OP_FOCUS) &&
                      listed && hold_valid && slot_free;
  assign step       = (state == aib_pkg::S_RUN) &&
                      !((op_q == aib_pkg::OP_FOCUS) && listed && hold_valid && !slot_free);
  assign push_final = (state == aib_pkg::S_DONE) && slot_free;

  // truncate toward zero on the divide by 256
  assign prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aib_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aib_pkg::S_IDLE: begin
        if (item_fire) begin
          unique case (aib_pkg::op_t'(op))
            aib_pkg::OP_ACCESS: state_next = aib_pkg::S_MUL;
            aib_pkg::OP_DECAY,
            aib_pkg::OP_FOCUS:  state_next = aib_pkg::S_RUN;
            default:            state_next = aib_pkg::S_IDLE;
          endcase
        end
      end
      aib_pkg::S_MUL: state_next = aib_pkg::S_DIV;
      aib_pkg::S_DIV: state_next = aib_pkg::S_RUN;
      aib_pkg::S_RUN: begin
        if (step && (k == K_LAST)) state_next = aib_pkg::S_DONE;
      end
      aib_pkg::S_DONE: begin
        if (slot_free) state_next = aib_pkg::S_IDLE;
      end
      default: state_next = aib_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wage           <= aib_pkg::WAGE_RST;
      rent           <= aib_pkg::RENT_RST;
      imp_max        <= aib_pkg::IMP_MAX_RST;
      imp_min        <= aib_pkg::IMP_MIN_RST;
      entries_in_use <= aib_pkg::LIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (aib_pkg::reg_idx_t'(cfg_index))
        aib_pkg::REG_WAGE:    wage           <= cfg_data[aib_pkg::WAGE_W-1:0];
        aib_pkg::REG_RENT:    rent           <= cfg_data[aib_pkg::RENT_W-1:0];
        aib_pkg::REG_IMP_MAX: imp_max        <= cfg_data[IMP_W-1:0];
        aib_pkg::REG_IMP_MIN: imp_min        <= cfg_data[IMP_W-1:0];
        aib_pkg::REG_LIVE:    entries_in_use <= cfg_data[aib_pkg::LIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      tick       <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        hold_valid <= 1'b0;
        if (op == aib_pkg::OP_ACCESS) tick <= tick + STAMP_W'(1);
      end
      if (step) begin
        k <= (k == K_LAST) ? '0 : k + K_W'(1);
        if (ctrl.hit || listed) hold_valid <= 1'b1;
      end
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (item_fire) begin
      op_q     <= aib_pkg::op_t'(op);
      idx_q    <= entry_index;
      act_q    <= activity;
      thr_q    <= focus_threshold;
      hold_idx <= (op == aib_pkg::OP_ACCESS) ? entry_index : '0;
      total    <= '0;
    end
    if (state == aib_pkg::S_MUL) begin
      prod <= PROD_W'(act_q) * PROD_W'(signed'({1'b0, wage}));
    end
    if (state == aib_pkg::S_DIV) begin
      inc <= INC_W'(prod_rnd >>> aib_pkg::FRAC_W);
    end
    if (step) begin
      if (ctrl.hit) begin
        hold_imp   <= nxt_imp;
        hold_stamp <= nxt.stamp;
      end
      if (listed) begin
        hold_idx   <= aib_pkg::INDEX_W'(k);
        hold_imp   <= cur_imp;
        hold_stamp <= cur.stamp;
      end
      if ((op_q == aib_pkg::OP_DECAY) && ctrl.live) begin
        total <= total + TOTAL_W'(nxt_imp);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push_mid || push_final) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid) begin
      found            <= 1'b1;
      result_index     <= hold_idx;
      importance       <= hold_imp;
      stamp            <= hold_stamp;
      total_importance <= '0;
      last             <= 1'b0;
    end else if (push_final) begin
      found            <= hold_valid;
      result_index     <= hold_idx;
      importance       <= hold_valid ? hold_imp : '0;
      stamp            <= hold_valid ? hold_stamp : '0;
      total_importance <= total;
      last             <= 1'b1;
    end
  end

  a_idle_k_home: assert property (@(posedge clk) disable iff (rst)
    (state == aib_pkg::S_IDLE) |-> (k == '0))
    else $error("ring not at home position while idle");

  a_decay_no_hold: assert property (@(posedge clk) disable iff (rst)
    ((state != aib_pkg::S_IDLE) && (op_q == aib_pkg::OP_DECAY)) |-> !hold_valid)
    else $error("decay captured an entry");

  a_tick_only_access: assert property (@(posedge clk) disable iff (rst)
    !(item_fire && (op == aib_pkg::OP_ACCESS)) |=> $stable(tick))
    else $error("tick moved without an access");

  a_access_stamp: assert property (@(posedge clk) disable iff (rst)
    ((state == aib_pkg::S_DONE) && (op_q == aib_pkg::OP_ACCESS) && hold_valid)
      |-> (hold_stamp == tick))
    else $error("access stamp differs from tick");

endmodule

`default_nettype wire

// ----- tb/sv/importance_bank_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// importance_bank_tb_pkg
// Scoreboard for the attention importance bank. It keeps its own copy of the
// entry table, tick counter and registers, and queues the results that each
// accepted transaction should produce.
// ----------------------------------------------------------------------------
package importance_bank_tb_pkg;
  import aib_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  typedef struct packed {
    logic                      found;
    logic [INDEX_W-1:0]        idx;
    logic signed [IMP_W-1:0]   imp;
    logic [STAMP_W-1:0]        stamp;
    logic signed [TOTAL_W-1:0] total;
    logic                      last;
  } bank_result_t;

  class bank_scoreboard;
    logic [WAGE_W-1:0]       wage;
    logic [RENT_W-1:0]       rent;
    logic signed [IMP_W-1:0] imp_hi;
    logic signed [IMP_W-1:0] imp_lo;
    logic [LIVE_W-1:0]       live_reg;
    logic signed [IMP_W-1:0] imp_table[SLOTS];
    logic [STAMP_W-1:0]      stamp_table[SLOTS];
    logic [STAMP_W-1:0]      ticks;
    bank_result_t            predicted[$];
    int                      errors;

    function new();
      wage     = WAGE_RST;
      rent     = RENT_RST;
      imp_hi   = IMP_MAX_RST;
      imp_lo   = IMP_MIN_RST;
      live_reg = LIVE_RST;
      foreach (imp_table[i]) begin
        imp_table[i]   = '0;
        stamp_table[i] = '0;
      end
      ticks  = '0;
      errors = 0;
    endfunction

    function int pending();
      return predicted.size();
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_WAGE:    wage     = data[WAGE_W-1:0];
        REG_RENT:    rent     = data[RENT_W-1:0];
        REG_IMP_MAX: imp_hi   = data[IMP_W-1:0];
        REG_IMP_MIN: imp_lo   = data[IMP_W-1:0];
        REG_LIVE:    live_reg = data[LIVE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(logic found, int idx, int imp, logic [STAMP_W-1:0] stamp, int total,
                       logic last);
      bank_result_t r;
      r.found = found;
      r.idx   = INDEX_W'(idx);
      r.imp   = IMP_W'(imp);
      r.stamp = stamp;
      r.total = TOTAL_W'(total);
      r.last  = last;
      predicted.push_back(r);
    endfunction

    function void apply_item(logic [OP_W-1:0] code, logic [INDEX_W-1:0] index,
                             logic signed [ACT_W-1:0] act, logic signed [IMP_W-1:0] thr);
      int live;
      int pay;
      int v;
      int total;
      int final_hit;
      live      = (live_reg > SLOTS) ? SLOTS : int'(live_reg);
      total     = 0;
      final_hit = -1;
      case (code)
        OP_ACCESS: begin
          ticks = ticks + 1;
          if (int'(index) < live) begin
            pay = (int'(act) * int'(wage)) / 256;
            v   = int'(imp_table[index]) + pay;
            if (v > int'(imp_hi)) v = int'(imp_hi);
            if (v < int'(imp_lo)) v = int'(imp_lo);
            imp_table[index]   = IMP_W'(v);
            stamp_table[index] = ticks;
            push(1'b1, int'(index), v, ticks, 0, 1'b1);
          end else begin
            push(1'b0, int'(index), 0, '0, 0, 1'b1);
          end
        end
        OP_DECAY: begin
          for (int i = 0; i < live; i++) begin
            v = int'(imp_table[i]) - int'(rent);
            if (v < int'(imp_lo)) v = int'(imp_lo);
            imp_table[i] = IMP_W'(v);
            total += v;
          end
          push(1'b0, 0, 0, '0, total, 1'b1);
        end
        OP_FOCUS: begin
          for (int i = 0; i < live; i++) begin
            if (imp_table[i] > thr) final_hit = i;
          end
          for (int i = 0; i < live; i++) begin
            if (imp_table[i] > thr) begin
              push(1'b1, i, int'(imp_table[i]), stamp_table[i], 0, i == final_hit);
            end
          end
          if (final_hit < 0) push(1'b0, 0, 0, '0, 0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare(string field, logic signed [32:0] got, logic signed [32:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(bank_result_t got);
      bank_result_t want;
      if (predicted.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      want = predicted.pop_front();
      compare("found", got.found, want.found);
      compare("result_index", got.idx, want.idx);
      compare("importance", got.imp, want.imp);
      compare("stamp", got.stamp, want.stamp);
      compare("total_importance", got.total, want.total);
      compare("last", got.last, want.last);
    endtask
  endclass

endpackage

// ----- tb/sv/attention_importance_bank_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attention_importance_bank_tb
// Drives access, decay, focus and unused-op transactions through the bank
// under several register settings, with random idling on both channels, and
// checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module attention_importance_bank_tb;
  import aib_pkg::*;
  import importance_bank_tb_pkg::*;

  localparam logic [OP_W-1:0]          OP_UNKNOWN    = 2'd3;
  localparam logic signed [ACT_W-1:0]  ACT_LO        = 16'sh8000;
  localparam logic signed [ACT_W-1:0]  ACT_HI        = 16'sh7fff;
  localparam logic signed [IMP_W-1:0]  IMP_FLOOR     = 15'sh4000;
  localparam logic signed [IMP_W-1:0]  IMP_CEIL      = 15'sh3fff;
  localparam int                       CFG_SLOTS     = 1 << CFG_IDX_W;
  localparam int                       DRAIN         = 2 * SLOTS + 10;
  localparam int                       QUIET_LIMIT   = 5000;
  localparam int                       RANDOM_PHASES = 8;
  localparam int                       PHASE_ITEMS   = 50;

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_ready;
  logic [OP_W-1:0]           op;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [ACT_W-1:0]   activity;
  logic signed [IMP_W-1:0]   focus_threshold;
  logic                      result_valid;
  logic                      result_ready = 1'b1;
  logic                      found;
  logic [INDEX_W-1:0]        result_index;
  logic signed [IMP_W-1:0]   importance;
  logic [STAMP_W-1:0]        stamp;
  logic signed [TOTAL_W-1:0] total_importance;
  logic                      last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  bank_scoreboard sb;
  bank_result_t   seen;
  bit             calm       = 1'b0;
  int             gap_pct    = 0;
  int             stall_pct  = 0;
  int             stall_left = 0;
  int             quiet      = 0;

  attention_importance_bank dut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    if (calm) begin
      result_ready = 1'b1;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      result_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      result_ready = 1'b0;
      stall_left   = $urandom_range(0, 10);
    end else begin
      result_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      seen = '{found, result_index, importance, stamp, total_importance, last};
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // unused upper bits of the narrow registers carry noise
  task automatic set_regs(int w, int rt, int hi, int lo, int lv);
    write_reg(REG_WAGE, {(CFG_W-WAGE_W)'($urandom), w[WAGE_W-1:0]});
    write_reg(REG_RENT, {(CFG_W-RENT_W)'($urandom), rt[RENT_W-1:0]});
    write_reg(REG_IMP_MAX, hi[IMP_W-1:0]);
    write_reg(REG_IMP_MIN, lo[IMP_W-1:0]);
    write_reg(REG_LIVE, {(CFG_W-LIVE_W)'($urandom), lv[LIVE_W-1:0]});
  endtask

  task automatic send_item(logic [OP_W-1:0] code, logic [INDEX_W-1:0] index,
                           logic signed [ACT_W-1:0] act, logic signed [IMP_W-1:0] thr);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item_valid      = 1'b1;
    op              = code;
    entry_index     = index;
    activity        = act;
    focus_threshold = thr;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.apply_item(code, index, act, thr);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // unused ops leave nothing to wait for, so allow a full pass afterwards
  task automatic settle();
    hold_until_drained();
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_regs();
    int w;
    int rt;
    int hi;
    int lo;
    int lv;
    case ($urandom_range(0, 9))
      0: w = 0;
      1: w = 1023;
      default: w = $urandom_range(1, 1000);
    endcase
    rt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 30);
    case ($urandom_range(0, 5))
      0: begin
        hi = 16383;
        lo = -16384;
      end
      1: begin
        hi = -int'($urandom_range(0, 500));
        lo = int'($urandom_range(0, 500));
      end
      default: begin
        hi = $urandom_range(0, 3000);
        lo = -int'($urandom_range(0, 3000));
      end
    endcase
    case ($urandom_range(0, 9))
      0: lv = 0;
      1: lv = $urandom_range(SLOTS + 1, (1 << LIVE_W) - 1);
      2: lv = SLOTS;
      default: lv = $urandom_range(1, SLOTS);
    endcase
    set_regs(w, rt, hi, lo, lv);
  endtask

  task automatic random_item();
    int                      r;
    logic [OP_W-1:0]         code;
    logic signed [ACT_W-1:0] act;
    logic signed [IMP_W-1:0] thr;
    r = $urandom_range(0, 99);
    if (r < 55) code = OP_ACCESS;
    else if (r < 70) code = OP_DECAY;
    else if (r < 94) code = OP_FOCUS;
    else code = OP_UNKNOWN;
    case ($urandom_range(0, 7))
      0: act = ACT_LO;
      1: act = ACT_HI;
      2, 3: act = ACT_W'($urandom);
      default: act = ACT_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
    if ($urandom_range(0, 1) == 1) thr = IMP_W'($urandom);
    else thr = IMP_W'(int'($urandom_range(0, 2400)) - 1200);
    send_item(code, INDEX_W'($urandom), act, thr);
  endtask

  initial begin
    int k;
    int ph;
    sb              = new();
    rst             = 1'b1;
    item_valid      = 1'b0;
    op              = OP_ACCESS;
    entry_index     = '0;
    activity        = '0;
    focus_threshold = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_WAGE;
    cfg_data        = '0;
    gap_pct         = 20;
    stall_pct       = 20;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset registers: nothing live, ticks still advance
    send_item(OP_ACCESS, 4'd15, ACT_HI, '0);
    send_item(OP_DECAY, '0, '0, '0);
    send_item(OP_FOCUS, '0, '0, IMP_FLOOR);
    send_item(OP_UNKNOWN, 4'd9, ACT_HI, IMP_CEIL);
    settle();

    // widest clamps, full table, saturating pay and truncation toward zero
    set_regs(1000, 1000, 16383, -16384, SLOTS);
    send_item(OP_ACCESS, 4'd0, ACT_HI, '0);
    send_item(OP_ACCESS, 4'd15, ACT_LO, '0);
    send_item(OP_ACCESS, 4'd3, 16'sd1, '0);
    send_item(OP_ACCESS, 4'd4, -16'sd1, '0);
    send_item(OP_FOCUS, '0, '0, IMP_FLOOR);
    send_item(OP_FOCUS, '0, '0, IMP_CEIL);
    send_item(OP_DECAY, '0, '0, '0);
    send_item(OP_FOCUS, '0, '0, '0);
    send_item(OP_ACCESS, 4'd15, '0, '0);
    settle();

    // unused register slots, inverted clamps, live count past the table
    for (k = int'(REG_LIVE) + 1; k < CFG_SLOTS; k++) write_reg(CFG_IDX_W'(k), '1);
    set_regs(0, 0, -5000, 5000, (1 << LIVE_W) - 1);
    send_item(OP_ACCESS, 4'd7, ACT_HI, '0);
    send_item(OP_ACCESS, 4'd2, ACT_LO, '0);
    send_item(OP_DECAY, '0, '0, '0);
    send_item(OP_FOCUS, '0, '0, 15'sd4999);
    send_item(OP_FOCUS, '0, '0, 15'sd5000);
    send_item(OP_ACCESS, 4'd12, 16'sh0100, '0);
    settle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_regs();
      calm      = (ph == RANDOM_PHASES - 1);
      gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
      repeat (PHASE_ITEMS) begin
        if (!calm && $urandom_range(0, 39) == 0) hold_until_drained();
        random_item();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- attention_importance_bank.f -----
hw/rtl/aib_pkg.sv
hw/rtl/aib_cell.sv
hw/rtl/aib_head.sv
hw/rtl/attention_importance_bank.sv
tb/sv/importance_bank_tb_pkg.sv
tb/sv/attention_importance_bank_tb.sv
